FILE: sv/bmm_pkg.sv
// Shared types and constants for the batched matrix multiply block.
// No dependencies; every other file except bmm_ram imports this package.
`default_nettype none

package bmm_pkg;

  localparam int DATA_W      = 32;
  localparam int DIM_W       = 7;
  localparam int IDX_W       = 6;
  localparam int LOAD_ADDR_W = 12;
  localparam int CMD_W       = 2;
  // holds 127*127*127, the largest address or limit any item can form
  localparam int LIM_W       = 21;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam int DEF_STORE_DEPTH = 4096;
  localparam int DEF_MAX_DIM     = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_NUM_BATCHES  = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS     = 2'd1;
  localparam logic [1:0] REG_INNER_LENGTH = 2'd2;
  localparam logic [1:0] REG_NUM_COLS     = 2'd3;

  localparam logic [DIM_W-1:0] RST_NUM_BATCHES  = 7'd2;
  localparam logic [DIM_W-1:0] RST_NUM_ROWS     = 7'd3;
  localparam logic [DIM_W-1:0] RST_INNER_LENGTH = 7'd5;
  localparam logic [DIM_W-1:0] RST_NUM_COLS     = 7'd4;

  typedef struct packed {
    logic [DIM_W-1:0] num_batches;
    logic [DIM_W-1:0] num_rows;
    logic [DIM_W-1:0] inner_length;
    logic [DIM_W-1:0] num_cols;
    logic             ok;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CHECK,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;     // capture the accepted item
    logic check;     // range check, load write, loop setup
    logic issue;     // issue one pair of store reads
    logic out_load;  // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic err;
    logic is_query;
    logic last_issue;
    logic pipe_busy;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/bmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/bmm_cfg.sv
// Configuration registers behind the APB-style port, plus the shape check.
// Depends on bmm_pkg.
`default_nettype none

module bmm_cfg #(
  parameter int MAX_DIM = bmm_pkg::DEF_MAX_DIM
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bmm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bmm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [bmm_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output bmm_pkg::cfg_t                      cfg
);
  import bmm_pkg::*;

  logic [DIM_W-1:0] nb_r, nr_r, ni_r, nc_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_r <= RST_NUM_BATCHES;
      nr_r <= RST_NUM_ROWS;
      ni_r <= RST_INNER_LENGTH;
      nc_r <= RST_NUM_COLS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_NUM_BATCHES:  nb_r <= pwdata[DIM_W-1:0];
        REG_NUM_ROWS:     nr_r <= pwdata[DIM_W-1:0];
        REG_INNER_LENGTH: ni_r <= pwdata[DIM_W-1:0];
        REG_NUM_COLS:     nc_r <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NUM_BATCHES:  prdata = PDATA_W'(nb_r);
      REG_NUM_ROWS:     prdata = PDATA_W'(nr_r);
      REG_INNER_LENGTH: prdata = PDATA_W'(ni_r);
      REG_NUM_COLS:     prdata = PDATA_W'(nc_r);
      default:          prdata = '0;
    endcase
  end

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return (d != '0) && (LIM_W'(d) <= LIM_W'(MAX_DIM));
  endfunction

  always_comb begin
    cfg.num_batches  = nb_r;
    cfg.num_rows     = nr_r;
    cfg.inner_length = ni_r;
    cfg.num_cols     = nc_r;
    cfg.ok           = dim_ok(nb_r) && dim_ok(nr_r) && dim_ok(ni_r) && dim_ok(nc_r);
  end

endmodule

`default_nettype wire

FILE: sv/bmm_ctrl.sv
// Controller state machine: sequences address math, range check, the
// multiply-accumulate loop and result hand-off. Depends on bmm_pkg.
`default_nettype none

module bmm_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [bmm_pkg::CMD_W-1:0] in_cmd,
  output logic                           in_ready,
  input  wire logic                      out_ready,
  output bmm_pkg::ctrl_cmd_t             cmd,
  input  wire bmm_pkg::dp_status_t       status
);
  import bmm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_free;

  assign out_free = !status.out_full || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // unused command is swallowed without a result
        if (in_valid && (cmd_e'(in_cmd) != CMD_NONE)) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MUL3;
      ST_MUL3:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = (status.is_query && !status.err) ? ST_RUN : ST_DONE;
      end
      ST_RUN: begin
        if (status.last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.latch    = 1'b0;
    cmd.check    = 1'b0;
    cmd.issue    = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      ST_CHECK: cmd.check = 1'b1;
      ST_RUN:   cmd.issue = 1'b1;
      ST_DONE:  cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/bmm_dp.sv
// Datapath: item capture, address arithmetic, range check, A/B stores,
// multiply-accumulate pipeline and output register. Depends on bmm_pkg, bmm_ram.
`default_nettype none

module bmm_dp #(
  parameter int STORE_DEPTH = bmm_pkg::DEF_STORE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bmm_pkg::cfg_t                    cfg,
  input  wire bmm_pkg::ctrl_cmd_t               cmd,
  output bmm_pkg::dp_status_t                   status,
  input  wire logic [bmm_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [bmm_pkg::LOAD_ADDR_W-1:0]  in_load_addr,
  input  wire logic signed [bmm_pkg::DATA_W-1:0] in_load_value,
  input  wire logic [bmm_pkg::IDX_W-1:0]        in_batch_index,
  input  wire logic [bmm_pkg::IDX_W-1:0]        in_row_index,
  input  wire logic [bmm_pkg::IDX_W-1:0]        in_col_index,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic signed [bmm_pkg::DATA_W-1:0]     out_product_value,
  output logic                                  out_error_flag
);
  import bmm_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(STORE_DEPTH);

  // captured item
  cmd_e              cmd_r;
  logic [LOAD_ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] value_r;
  logic [IDX_W-1:0]  b_r, i_r, j_r;

  // address arithmetic, one multiply per register stage
  logic [LIM_W-1:0]  t1_r, t1_nxt;   // nb*nr, nb*ni, or b*nr+i
  logic [LIM_W-1:0]  u1_r, u1_nxt;   // b*ni
  logic [LIM_W-1:0]  t2_r, t2_nxt;   // load limit, or A base address
  logic [LIM_W-1:0]  bf_r, bf_nxt;   // first B address
  logic [LIM_W-1:0]  bl_r, bl_nxt;   // last B address

  logic [LIM_W-1:0]  a_last, addr_l;
  logic              load_bad, query_bad, err_now;
  logic              err_r;

  logic [LIM_W-1:0]  a_ptr_r, b_ptr_r;
  logic [DIM_W-1:0]  k_r;
  logic              v1_r, v2_r;
  logic [DATA_W-1:0] prod_r, acc_r;
  logic [DATA_W-1:0] a_rdata, b_rdata;
  logic              a_we, b_we;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_err_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r   <= cmd_e'(in_cmd);
      addr_r  <= in_load_addr;
      value_r <= in_load_value;
      b_r     <= in_batch_index;
      i_r     <= in_row_index;
      j_r     <= in_col_index;
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_LOAD_A: t1_nxt = LIM_W'(cfg.num_batches) * LIM_W'(cfg.num_rows);
      CMD_LOAD_B: t1_nxt = LIM_W'(cfg.num_batches) * LIM_W'(cfg.inner_length);
      default:    t1_nxt = LIM_W'(b_r) * LIM_W'(cfg.num_rows) + LIM_W'(i_r);
    endcase
    u1_nxt = LIM_W'(b_r) * LIM_W'(cfg.inner_length);
    t2_nxt = t1_r * LIM_W'((cmd_r == CMD_LOAD_B) ? cfg.num_cols : cfg.inner_length);
    bf_nxt = u1_r * LIM_W'(cfg.num_cols) + LIM_W'(j_r);
    bl_nxt = bf_r + LIM_W'(cfg.inner_length - DIM_W'(1)) * LIM_W'(cfg.num_cols);
  end

  always_ff @(posedge clk) begin
    t1_r <= t1_nxt;
    u1_r <= u1_nxt;
    t2_r <= t2_nxt;
    bf_r <= bf_nxt;
    bl_r <= bl_nxt;
  end

  always_comb begin
    addr_l    = LIM_W'(addr_r);
    a_last    = t2_r + LIM_W'(cfg.inner_length - DIM_W'(1));
    load_bad  = (addr_l >= t2_r) || (addr_l >= DEPTH_L);
    query_bad = (DIM_W'(b_r) >= cfg.num_batches) || (DIM_W'(i_r) >= cfg.num_rows) ||
                (DIM_W'(j_r) >= cfg.num_cols) || (a_last >= DEPTH_L) || (bl_r >= DEPTH_L);
    err_now   = !cfg.ok || ((cmd_r == CMD_QUERY) ? query_bad : load_bad);
  end

  assign a_we = cmd.check && !err_now && (cmd_r == CMD_LOAD_A);
  assign b_we = cmd.check && !err_now && (cmd_r == CMD_LOAD_B);

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (AW'(addr_r)),
    .wdata (value_r),
    .raddr (AW'(a_ptr_r)),
    .rdata (a_rdata)
  );

  bmm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (AW'(addr_r)),
    .wdata (value_r),
    .raddr (AW'(b_ptr_r)),
    .rdata (b_rdata)
  );

  // B address strides by num_cols per k step
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      err_r   <= err_now;
      a_ptr_r <= t2_r;
      b_ptr_r <= bf_r;
      k_r     <= '0;
    end else if (cmd.issue) begin
      a_ptr_r <= a_ptr_r + LIM_W'(1);
      b_ptr_r <= b_ptr_r + LIM_W'(cfg.num_cols);
      k_r     <= k_r + DIM_W'(1);
    end
  end

  // read -> multiply -> accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a_rdata * b_rdata;
    if (cmd.check) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= ((cmd_r == CMD_QUERY) && !err_r) ? acc_r : '0;
      out_err_r   <= err_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_error_flag    = out_err_r;

  always_comb begin
    status.err        = err_now;
    status.is_query   = (cmd_r == CMD_QUERY);
    status.last_issue = (k_r == cfg.inner_length - DIM_W'(1));
    status.pipe_busy  = v1_r || v2_r;
    status.out_full   = out_valid_r;
  end

endmodule

`default_nettype wire

FILE: sv/batched_matrix_multiply.sv
// Top level of the batched matrix multiply block: config registers,
// controller and datapath. Depends on bmm_pkg, bmm_cfg, bmm_ctrl, bmm_dp.
//
//   channel | handshake             | payload
//   --------+-----------------------+--------------------------------------------
//   in      | in_valid / in_ready   | cmd, load_addr, load_value, b/i/j indices
//   out     | out_valid / out_ready | product_value, error_flag
//   cfg     | psel/penable/pwrite   | paddr, pwdata, prdata (pready tied high)
//
// A query goes through MUL1-MUL3, CHECK, RUN, DRAIN and DONE from accept to the
// result register; the multiply-accumulate loop reads one A and one B element per
// cycle through the single read port of each store. Loads and rejected items skip
// RUN and DRAIN; an unused command is dropped in IDLE. rst_n is synchronous;
// store contents are not cleared. The next item is accepted while a result
// waits in the output register; a held result stalls only the next hand-off.
`default_nettype none

module batched_matrix_multiply #(
  parameter int STORE_DEPTH = bmm_pkg::DEF_STORE_DEPTH,
  parameter int MAX_DIM     = bmm_pkg::DEF_MAX_DIM
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [bmm_pkg::CMD_W-1:0]         in_cmd,
  input  wire logic [bmm_pkg::LOAD_ADDR_W-1:0]   in_load_addr,
  input  wire logic signed [bmm_pkg::DATA_W-1:0] in_load_value,
  input  wire logic [bmm_pkg::IDX_W-1:0]         in_batch_index,
  input  wire logic [bmm_pkg::IDX_W-1:0]         in_row_index,
  input  wire logic [bmm_pkg::IDX_W-1:0]         in_col_index,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [bmm_pkg::DATA_W-1:0]      out_product_value,
  output logic                                   out_error_flag,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bmm_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [bmm_pkg::PDATA_W-1:0]       pwdata,
  output logic      [bmm_pkg::PDATA_W-1:0]       prdata,
  output logic                                   pready
);
  import bmm_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  bmm_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  bmm_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .cmd               (cmd),
    .status            (status),
    .in_cmd            (in_cmd),
    .in_load_addr      (in_load_addr),
    .in_load_value     (in_load_value),
    .in_batch_index    (in_batch_index),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_product_value (out_product_value),
    .out_error_flag    (out_error_flag)
  );

endmodule

`default_nettype wire

FILE: sv/bmm_checker.sv
// Port-level checks for batched_matrix_multiply, bound to the top level.
// Depends on bmm_pkg.
`default_nettype none

module bmm_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [bmm_pkg::CMD_W-1:0]         in_cmd,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [bmm_pkg::DATA_W-1:0] out_product_value,
  input wire logic                              out_error_flag
);
  import bmm_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_product_value) &&
                                $stable(out_error_flag))
    else $error("result changed or dropped while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_product_value == '0)
    else $error("error result carries a nonzero value");

  // unused command leaves the block ready for the next item
  a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_NONE) |=> in_ready)
    else $error("unused command stalled the input");

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd != CMD_NONE) |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule

bind batched_matrix_multiply bmm_checker u_bmm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_cmd            (in_cmd),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_product_value (out_product_value),
  .out_error_flag    (out_error_flag)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for batched_matrix_multiply: loads A/B elements, queries C
// and checks every result against an in-bench C[b,i,j] calculator.
// Depends on bmm_pkg and the batched_matrix_multiply RTL.
module tb_top;
  import bmm_pkg::*;

  localparam int DEPTH        = DEF_STORE_DEPTH;
  localparam int DIM_MAX      = DEF_MAX_DIM;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_PCT    = 34;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    cmd_e                   cmd;
    logic [LOAD_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]      value;
    logic [IDX_W-1:0]       b;
    logic [IDX_W-1:0]       i;
    logic [IDX_W-1:0]       j;
  } mm_item_t;

  typedef struct {
    logic [DATA_W-1:0] product;
    logic              err;
  } mm_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic [LOAD_ADDR_W-1:0]   in_load_addr = '0;
  logic [DATA_W-1:0]        in_load_value = '0;
  logic [IDX_W-1:0]         in_batch_index = '0;
  logic [IDX_W-1:0]         in_row_index = '0;
  logic [IDX_W-1:0]         in_col_index = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_product_value;
  logic                     out_error_flag;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  // shape as currently programmed
  int shape_batches = int'(RST_NUM_BATCHES);
  int shape_rows    = int'(RST_NUM_ROWS);
  int shape_inner   = int'(RST_INNER_LENGTH);
  int shape_cols    = int'(RST_NUM_COLS);

  logic [DATA_W-1:0] a_elems [DEPTH];
  logic [DATA_W-1:0] b_elems [DEPTH];
  bit                a_loaded [DEPTH];
  bit                b_loaded [DEPTH];

  mm_item_t   pending_items[$];
  mm_result_t expected_c[$];
  mm_item_t   cur_item;
  mm_result_t want;
  logic       ready_next;

  int items_planned = 0;
  int items_taken = 0;
  int results_seen = 0;
  int hold_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  batched_matrix_multiply u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_load_addr      (in_load_addr),
    .in_load_value     (in_load_value),
    .in_batch_index    (in_batch_index),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_product_value (out_product_value),
    .out_error_flag    (out_error_flag),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit shape_ok();
    return shape_batches >= 1 && shape_batches <= DIM_MAX &&
           shape_rows >= 1 && shape_rows <= DIM_MAX &&
           shape_inner >= 1 && shape_inner <= DIM_MAX &&
           shape_cols >= 1 && shape_cols <= DIM_MAX;
  endfunction

  // number of writable entries of A or B, capped at the store size
  function automatic int store_limit(bit for_b);
    int lim;
    lim = for_b ? shape_batches * shape_inner * shape_cols
                : shape_batches * shape_rows * shape_inner;
    return (lim < DEPTH) ? lim : DEPTH;
  endfunction

  function automatic int a_index(int b, int i, int k);
    return (b * shape_rows + i) * shape_inner + k;
  endfunction

  function automatic int b_index(int b, int k, int j);
    return (b * shape_inner + k) * shape_cols + j;
  endfunction

  function automatic bit query_fits(int b, int i, int j);
    if (b >= shape_batches || i >= shape_rows || j >= shape_cols) return 1'b0;
    return a_index(b, i, shape_inner - 1) < DEPTH && b_index(b, shape_inner - 1, j) < DEPTH;
  endfunction

  // updates the A/B copies and queues the C result the item should produce
  function automatic void apply_item(mm_item_t it);
    mm_result_t r;
    logic [DATA_W-1:0] acc;
    if (it.cmd == CMD_NONE) return;
    r.product = '0;
    r.err = 1'b1;
    if (shape_ok()) begin
      case (it.cmd)
        CMD_LOAD_A: begin
          if (int'(it.addr) < store_limit(1'b0)) begin
            a_elems[it.addr] = it.value;
            r.err = 1'b0;
          end
        end
        CMD_LOAD_B: begin
          if (int'(it.addr) < store_limit(1'b1)) begin
            b_elems[it.addr] = it.value;
            r.err = 1'b0;
          end
        end
        default: begin
          if (query_fits(it.b, it.i, it.j)) begin
            acc = '0;
            for (int k = 0; k < shape_inner; k++)
              acc += a_elems[a_index(it.b, it.i, k)] * b_elems[b_index(it.b, k, it.j)];
            r.product = acc;
            r.err = 1'b0;
          end
        end
      endcase
    end
    expected_c.push_back(r);
  endfunction

  function automatic logic [DATA_W-1:0] corner_value(int n);
    case (n)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(7) < 3) return corner_value($urandom_range(4));
    return $urandom;
  endfunction

  // queue an item; tracks which store entries will hold data once it lands
  function automatic void send(cmd_e c, int addr, logic [DATA_W-1:0] v, int b, int i, int j);
    mm_item_t it;
    it.cmd = c;
    it.addr = addr[LOAD_ADDR_W-1:0];
    it.value = v;
    it.b = b[IDX_W-1:0];
    it.i = i[IDX_W-1:0];
    it.j = j[IDX_W-1:0];
    pending_items.push_back(it);
    if (c != CMD_NONE) items_planned++;
    if (c == CMD_LOAD_A && shape_ok() && addr < store_limit(1'b0)) a_loaded[addr] = 1'b1;
    if (c == CMD_LOAD_B && shape_ok() && addr < store_limit(1'b1)) b_loaded[addr] = 1'b1;
  endfunction

  function automatic void send_load(cmd_e c, int addr);
    send(c, addr, pick_value(), $urandom_range(63), $urandom_range(63), $urandom_range(63));
  endfunction

  function automatic void send_query(int b, int i, int j);
    send(CMD_QUERY, $urandom_range(DEPTH - 1), $urandom, b, i, j);
  endfunction

  // load whatever the query would read that has never been written, then query
  function automatic void fill_and_query(int b, int i, int j);
    if (shape_ok() && query_fits(b, i, j)) begin
      for (int k = 0; k < shape_inner; k++) begin
        if (!a_loaded[a_index(b, i, k)]) send_load(CMD_LOAD_A, a_index(b, i, k));
        if (!b_loaded[b_index(b, k, j)]) send_load(CMD_LOAD_B, b_index(b, k, j));
      end
    end
    send_query(b, i, j);
  endfunction

  function automatic void run_mix(int budget);
    int start;
    int pick;
    int lim;
    cmd_e c;
    start = items_planned;
    while (items_planned - start < budget) begin
      pick = $urandom_range(99);
      c = ($urandom_range(1) == 1) ? CMD_LOAD_B : CMD_LOAD_A;
      if (pick < 5) begin
        send(CMD_NONE, $urandom_range(DEPTH - 1), $urandom,
             $urandom_range(63), $urandom_range(63), $urandom_range(63));
      end else if (!shape_ok()) begin
        if (pick < 50) send_query($urandom_range(63), $urandom_range(63), $urandom_range(63));
        else send_load(c, $urandom_range(DEPTH - 1));
      end else if (pick < 55) begin
        // mostly out of range; an in-range hit gets its operands loaded first
        fill_and_query($urandom_range(63), $urandom_range(63), $urandom_range(63));
      end else if (pick < 75) begin
        lim = store_limit(c == CMD_LOAD_B);
        if (pick < 65 && lim < DEPTH) send_load(c, $urandom_range(DEPTH - 1, lim));
        else send_load(c, $urandom_range(lim - 1));
      end else begin
        fill_and_query($urandom_range(shape_batches - 1), $urandom_range(shape_rows - 1),
                       $urandom_range(shape_cols - 1));
      end
    end
  endfunction

  // runs under the reset shape: 2 batches, 3 rows, inner 5, 4 cols
  function automatic void directed_items();
    send(CMD_NONE, DEPTH - 1, 32'hffff_ffff, 63, 63, 63);
    send(CMD_LOAD_A, 29, 32'h7fff_ffff, 0, 0, 0);        // last A entry
    send(CMD_LOAD_A, 30, 32'h1234_5678, 63, 63, 63);     // one past A
    send(CMD_LOAD_A, DEPTH - 1, 32'hffff_ffff, 0, 0, 0);
    send(CMD_LOAD_B, 39, 32'h8000_0000, 63, 63, 63);     // last B entry
    send(CMD_LOAD_B, 40, 32'h0000_0001, 0, 0, 0);
    send(CMD_LOAD_B, DEPTH - 1, 32'h0000_0000, 63, 63, 63);
    send_query(2, 0, 0);
    send_query(0, 3, 0);
    send_query(0, 0, 4);
    send_query(63, 63, 63);
    for (int k = 0; k < 5; k++) begin
      if (!a_loaded[a_index(1, 2, k)])
        send(CMD_LOAD_A, a_index(1, 2, k), corner_value(k), 0, 0, 0);
      if (!b_loaded[b_index(1, k, 3)])
        send(CMD_LOAD_B, b_index(1, k, 3), corner_value(4 - k), 63, 63, 63);
    end
    send_query(1, 2, 3);
  endfunction

  // sampled on the falling edge so the driver's updates at the rising edge have settled
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_c.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    logic [PDATA_W-1:0] data;
    data = $urandom;
    data[DIM_W-1:0] = val[DIM_W-1:0];
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_NUM_BATCHES:  shape_batches = int'(data[DIM_W-1:0]);
      REG_NUM_ROWS:     shape_rows = int'(data[DIM_W-1:0]);
      REG_INNER_LENGTH: shape_inner = int'(data[DIM_W-1:0]);
      default:          shape_cols = int'(data[DIM_W-1:0]);
    endcase
  endtask

  task automatic set_shape(int nb, int nr, int ni, int nc);
    wait_idle();
    write_reg(REG_NUM_BATCHES, nb);
    write_reg(REG_NUM_ROWS, nr);
    write_reg(REG_INNER_LENGTH, ni);
    write_reg(REG_NUM_COLS, nc);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    run_mix(120);
    set_shape(1, 1, 1, 1);
    run_mix(40);
    set_shape(DIM_MAX, DIM_MAX, DIM_MAX, DIM_MAX);
    fill_and_query(0, $urandom_range(DIM_MAX - 1), $urandom_range(DIM_MAX - 1));
    run_mix(30);
    set_shape(0, 3, 127, 4);          // zero and all-ones register values
    run_mix(20);
    set_shape(2, DIM_MAX + 1, 3, 1);  // just above the largest dimension
    run_mix(15);
    set_shape(DIM_MAX, 1, 1, 1);
    run_mix(60);
    set_shape(1, 1, DIM_MAX, 1);
    run_mix(70);
    repeat (5) begin
      set_shape($urandom_range(1, 4), $urandom_range(1, 6), $urandom_range(1, 8),
                $urandom_range(1, 6));
      run_mix(50);
    end
    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_item(cur_item);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 &&
            ((items_taken >= 250 && items_taken < 400) || $urandom_range(99) >= STALL_PCT)) begin
          cur_item = pending_items.pop_front();
          in_cmd <= cur_item.cmd;
          in_load_addr <= cur_item.addr;
          in_load_value <= cur_item.value;
          in_batch_index <= cur_item.b;
          in_row_index <= cur_item.i;
          in_col_index <= cur_item.j;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: checks and back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_c.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h err %b",
                   $time, out_product_value, out_error_flag);
          fail_count++;
        end else begin
          want = expected_c.pop_front();
          if (out_product_value !== want.product) begin
            $display("%0t: product_value mismatch, expected %h actual %h",
                     $time, want.product, out_product_value);
            fail_count++;
          end
          if (out_error_flag !== want.err) begin
            $display("%0t: error_flag mismatch, expected %b actual %b",
                     $time, want.err, out_error_flag);
            fail_count++;
          end
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 60 || results_seen == 450) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (results_seen >= 250 && results_seen < 400) begin
        ready_next = 1'b1;
      end else begin
        ready_next = ($urandom_range(99) >= STALL_PCT);
      end
      out_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
